// ===== rtl/mwsm_pkg.sv =====
// Package for the moving window sum and mean unit.
// Field widths, queue depth and the queue entry type shared by all rtl files.
// No dependencies.
package mwsm_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int SUM_W          = 22;
   localparam int MEAN_W         = 16;
   localparam int LEN_W          = 7;
   localparam int MAX_WINDOW_DEF = 64;
   localparam int Q_DEPTH        = 2;

   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);

   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic                    full;
      logic [LEN_W-1:0]        len;
   } mwsm_entry_type;

endpackage

// ===== rtl/mwsm_front.sv =====
// Front end: request intake, window length register, sample history memory
// and running total. Pushes one entry per request into the queue.
// Depends on mwsm_pkg.
module mwsm_front #(
   parameter int MAX_WINDOW = mwsm_pkg::MAX_WINDOW_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [mwsm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                  req_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mwsm_pkg::LEN_W-1:0]            csr_window_length,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output mwsm_pkg::mwsm_entry_type              push_entry
);
   import mwsm_pkg::*;

   localparam int PTR_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int TOT_W   = SAMPLE_W + PTR_W + 1;
   localparam int IX_W    = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;
   localparam int LEN_TOP = (1 << LEN_W) - 1;
   localparam int MAX_LEN = (MAX_WINDOW < LEN_TOP) ? MAX_WINDOW : LEN_TOP;

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_UPD  = 2'b10
   } front_state_type;

   front_state_type             state_ff, state_in;
   logic [LEN_W-1:0]            len_ff, len_in;
   logic [LEN_W-1:0]            fill_ff, fill_in;
   logic [PTR_W-1:0]            wp_ff, wp_in;
   logic signed [TOT_W-1:0]     total_ff, total_in;
   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic                        last_ff;
   logic signed [SAMPLE_W-1:0]  rd_data_ff;
   logic signed [SAMPLE_W-1:0]  hist [MAX_WINDOW];

   logic [LEN_W-1:0]            len_eff;
   logic [IX_W-1:0]             wp_x, len_x, old_x;
   logic [PTR_W-1:0]            old_idx, wp_next;
   logic                        evict, full_new, accept, commit;
   logic [LEN_W-1:0]            fill_new;
   logic signed [TOT_W-1:0]     total_new;

   always_comb begin
      priority if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_LEN)) begin
         len_eff = LEN_W'(MAX_LEN);
      end else begin
         len_eff = len_ff;
      end
   end

   assign wp_x    = IX_W'(wp_ff);
   assign len_x   = IX_W'(len_eff);
   assign old_x   = (wp_x >= len_x) ? (wp_x - len_x) : (wp_x + IX_W'(MAX_WINDOW) - len_x);
   assign old_idx = old_x[PTR_W-1:0];
   assign wp_next = (wp_ff == PTR_W'(MAX_WINDOW - 1)) ? '0 : (wp_ff + 1'b1);

   assign evict     = (fill_ff >= len_eff);
   assign fill_new  = evict ? fill_ff : (fill_ff + 1'b1);
   assign full_new  = (fill_new >= len_eff);
   assign total_new = total_ff + TOT_W'(sample_ff)
                      - (evict ? TOT_W'(rd_data_ff) : TOT_W'(0));

   assign req_ready = (state_ff == F_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == F_UPD) && push_ready;

   assign push_valid      = (state_ff == F_UPD);
   assign push_entry.sum  = full_new ? SUM_W'(total_new) : '0;
   assign push_entry.full = full_new;
   assign push_entry.len  = len_eff;

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      fill_in  = fill_ff;
      wp_in    = wp_ff;
      total_in = total_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               state_in = F_UPD;
            end
         end
         F_UPD: begin
            if (commit) begin
               state_in = F_IDLE;
               if (last_ff) begin
                  fill_in  = '0;
                  wp_in    = '0;
                  total_in = '0;
               end else begin
                  fill_in  = fill_new;
                  wp_in    = wp_next;
                  total_in = total_new;
               end
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
      if (csr_valid && csr_ready) begin
         len_in   = csr_window_length;
         fill_in  = '0;
         wp_in    = '0;
         total_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         len_ff   <= LEN_RESET;
         fill_ff  <= '0;
         wp_ff    <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         fill_ff  <= fill_in;
         wp_ff    <= wp_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
         last_ff   <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= hist[old_idx];
      end
      if (commit) begin
         hist[wp_ff] <= sample_ff;
      end
   end

endmodule

// ===== rtl/mwsm_queue.sv =====
// Short queue of window entries between the front end and the divider.
// Depends on mwsm_pkg.
module mwsm_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  mwsm_pkg::mwsm_entry_type push_entry,
   output logic                     pop_valid,
   input  logic                     pop_ready,
   output mwsm_pkg::mwsm_entry_type pop_entry
);
   import mwsm_pkg::*;

   localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CNT_W = $clog2(Q_DEPTH + 1);

   mwsm_entry_type     slot_ff [Q_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : (wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(Q_DEPTH - 1)) ? '0 : (rd_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/mwsm_divider.sv =====
// Back end: bit-serial signed division of the window sum by the window
// length, with the response output register. Depends on mwsm_pkg.
module mwsm_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  mwsm_pkg::mwsm_entry_type            pop_entry,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mwsm_pkg::SUM_W-1:0]   rsp_window_sum,
   output logic signed [mwsm_pkg::MEAN_W-1:0]  rsp_window_mean,
   output logic                                rsp_window_full
);
   import mwsm_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_HOLD = 3'b100
   } back_state_type;

   back_state_type           state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [LEN_W-1:0]         rem_ff, rem_in;
   logic [LEN_W-1:0]         div_ff;
   logic                     neg_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic                     full_ff;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;

   logic [LEN_W:0]           rem_shift;
   logic                     take;
   logic                     accept;
   logic [SUM_W-1:0]         quo_signed;

   assign pop_ready = (state_ff == B_IDLE);
   assign accept    = pop_valid && pop_ready;
   assign rem_shift = {rem_ff, quo_ff[SUM_W-1]};
   assign take      = (rem_shift >= {1'b0, div_ff});
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   assign rsp_valid       = (state_ff == B_HOLD);
   assign rsp_window_sum  = sum_ff;
   assign rsp_window_mean = mean_ff;
   assign rsp_window_full = full_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      mean_in  = mean_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (accept) begin
               state_in = B_DIV;
               step_in  = '0;
               rem_in   = '0;
               quo_in   = pop_entry.sum[SUM_W-1] ? (~pop_entry.sum + 1'b1) : pop_entry.sum;
            end
         end
         B_DIV: begin
            if (step_ff == STEP_W'(SUM_W)) begin
               state_in = B_HOLD;
               mean_in  = MEAN_W'(quo_signed);
            end else begin
               step_in = step_ff + 1'b1;
               quo_in  = {quo_ff[SUM_W-2:0], take};
               rem_in  = take ? LEN_W'(rem_shift - {1'b0, div_ff}) : rem_shift[LEN_W-1:0];
            end
         end
         B_HOLD: begin
            if (rsp_ready) begin
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      mean_ff <= mean_in;
      if (accept) begin
         div_ff  <= pop_entry.len;
         neg_ff  <= pop_entry.sum[SUM_W-1];
         sum_ff  <= pop_entry.sum;
         full_ff <= pop_entry.full;
      end
   end

endmodule

// ===== rtl/moving_window_sum_and_mean_unit.sv =====
// Top level of the moving window sum and mean unit: front end, entry queue
// and divider back end. Depends on mwsm_pkg, mwsm_front, mwsm_queue, mwsm_divider.
//
//   channel  signals                                       direction
//   req      req_valid/ready, req_sample, req_last         in
//   rsp      rsp_valid/ready, rsp_window_sum/mean/full     out
//   csr      csr_valid/ready, csr_window_length            in
//
// The front end takes a request in its idle state and pushes its entry after the
// registered history read; it takes no new request until that entry is pushed.
// The divider takes an entry, forms 22 quotient bits at one a cycle, loads the mean
// and presents the response, and takes no new entry until that response is taken.
// Synchronous reset; the history memory has no reset.
// A stalled response holds the divider; the queue absorbs up to 2 further requests.
module moving_window_sum_and_mean_unit #(
   parameter int MAX_WINDOW = mwsm_pkg::MAX_WINDOW_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [mwsm_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mwsm_pkg::SUM_W-1:0]   rsp_window_sum,
   output logic signed [mwsm_pkg::MEAN_W-1:0]  rsp_window_mean,
   output logic                                rsp_window_full,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mwsm_pkg::LEN_W-1:0]          csr_window_length
);
   import mwsm_pkg::*;

   logic           push_valid, push_ready, pop_valid, pop_ready;
   mwsm_entry_type push_entry, pop_entry;

   mwsm_front #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_last          (req_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_window_length (csr_window_length),
      .push_valid        (push_valid),
      .push_ready        (push_ready),
      .push_entry        (push_entry)
   );

   mwsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   mwsm_divider u_divider (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_entry       (pop_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_window_sum  (rsp_window_sum),
      .rsp_window_mean (rsp_window_mean),
      .rsp_window_full (rsp_window_full)
   );

endmodule
